>>> hw/rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Shared sizes, operation codes and status codes for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  // Heap geometry. Slots are numbered 1..HEAP_DEPTH; slot s lives at address s-1.
  localparam int HEAP_DEPTH = 1024;
  localparam int ID_COUNT   = 1024;
  localparam int COST_BITS  = 32;
  localparam int ID_BITS    = 10;
  localparam int SLOT_BITS  = $clog2(HEAP_DEPTH + 1);
  localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
  localparam int PADDR_BITS = $clog2(ID_COUNT);
  localparam int CHILD_BITS = SLOT_BITS + 1;
  localparam int HEAP_WORD  = ID_BITS + COST_BITS;

  // Operation codes.
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_LOWER   = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;

  // One heap entry.
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [COST_BITS-1:0] cost;
  } entry_t;

endpackage

>>> hw/rtl/imh_ram.sv
// ----------------------------------------------------------------------------
// imh_ram
// Simple dual-port synchronous RAM: one write port, one read port, with
// registered read data (read-before-write on an address collision).
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/indexed_min_heap_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_top
// Binary min-heap of item ids keyed by cost, with a position map per id so
// that a present id can have its cost lowered in place.
//
//   channel  | handshake        | fields
//   ---------+------------------+-----------------------------------------
//   request  | start / busy     | opcode, item_id, cost
//   result   | done (one cycle) | out_id, out_cost, status, entry_count
//
// After reset the position map is cleared with busy high. An insert or
// lower-cost request climbs the heap one level at a time and an extract
// descends it one level at a time, after dispatch and lookup; the single
// read port of the heap RAM sets this pace. busy drops in the cycle done
// is shown; results cannot stall.
// ----------------------------------------------------------------------------
module indexed_min_heap_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [imh_pkg::ID_BITS-1:0]   item_id,
  input  logic [imh_pkg::COST_BITS-1:0] cost,
  output logic                          done,
  output logic [imh_pkg::ID_BITS-1:0]   out_id,
  output logic [imh_pkg::COST_BITS-1:0] out_cost,
  output logic [2:0]                    status,
  output logic [imh_pkg::SLOT_BITS-1:0] entry_count
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_UP      = 4'd4;
  localparam logic [3:0] S_UP_CMP  = 4'd5;
  localparam logic [3:0] S_DEC_POS = 4'd6;
  localparam logic [3:0] S_DEC_CMP = 4'd7;
  localparam logic [3:0] S_EXT_RT  = 4'd8;
  localparam logic [3:0] S_EXT_LST = 4'd9;
  localparam logic [3:0] S_DN      = 4'd10;
  localparam logic [3:0] S_DN_L    = 4'd11;
  localparam logic [3:0] S_DN_R    = 4'd12;
  localparam logic [3:0] S_DN_CMP  = 4'd13;

  localparam int SB = imh_pkg::SLOT_BITS;
  localparam int CB = imh_pkg::CHILD_BITS;
  localparam int AB = imh_pkg::ADDR_BITS;
  localparam int PB = imh_pkg::PADDR_BITS;

  // Registers.
  logic [3:0]            state, state_next;
  logic [PB-1:0]         clr_addr, clr_addr_next;
  logic [SB-1:0]         count, count_next;
  logic [1:0]            op_r, op_r_next;
  logic [imh_pkg::ID_BITS-1:0]   in_id, in_id_next;
  logic [imh_pkg::COST_BITS-1:0] in_cost, in_cost_next;
  logic [imh_pkg::ID_BITS-1:0]   res_id, res_id_next;
  logic [imh_pkg::COST_BITS-1:0] res_cost, res_cost_next;
  imh_pkg::entry_t       item, item_next;
  imh_pkg::entry_t       left, left_next;
  imh_pkg::entry_t       chosen, chosen_next;
  logic [SB-1:0]         loc, loc_next;
  logic [SB-1:0]         ch_slot, ch_slot_next;

  // Finish signals.
  logic                  fin;
  logic [2:0]            fin_status;

  // Memory ports.
  logic                  h_we;
  logic [AB-1:0]         h_waddr, h_raddr;
  imh_pkg::entry_t       h_wdata, h_rdata;
  logic                  p_we;
  logic [PB-1:0]         p_waddr, p_raddr;
  logic [SB-1:0]         p_wdata, p_rdata;

  logic [CB-1:0]         child;
  logic [SB-1:0]         parent;

  imh_ram #(.WIDTH(imh_pkg::HEAP_WORD), .ADDR_BITS(AB)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  imh_ram #(.WIDTH(SB), .ADDR_BITS(PB)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign child  = {loc, 1'b0};
  assign parent = loc >> 1;

  // Sequencer: each sift step reads, compares and writes back one heap level.
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    count_next    = count;
    op_r_next     = op_r;
    in_id_next    = in_id;
    in_cost_next  = in_cost;
    res_id_next   = res_id;
    res_cost_next = res_cost;
    item_next     = item;
    left_next     = left;
    chosen_next   = chosen;
    loc_next      = loc;
    ch_slot_next  = ch_slot;
    fin           = 1'b0;
    fin_status    = imh_pkg::ST_OK;
    h_we          = 1'b0;
    h_waddr       = AB'(loc - SB'(1));
    h_wdata       = item;
    h_raddr       = '0;
    p_we          = 1'b0;
    p_waddr       = item.id[PB-1:0];
    p_wdata       = loc;
    p_raddr       = in_id[PB-1:0];

    case (state)
      S_CLR: begin
        p_we          = 1'b1;
        p_waddr       = clr_addr;
        p_wdata       = '0;
        clr_addr_next = clr_addr + PB'(1);
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_r_next     = opcode;
          in_id_next    = item_id;
          in_cost_next  = cost;
          res_id_next   = item_id;
          res_cost_next = '0;
          state_next    = S_DISP;
        end
      end

      S_DISP: begin
        case (op_r)
          imh_pkg::OP_INSERT: begin
            state_next = S_INS_CHK;
          end
          imh_pkg::OP_LOWER: begin
            state_next = S_DEC_POS;
          end
          imh_pkg::OP_EXTRACT: begin
            if (count == '0) begin
              fin        = 1'b1;
              fin_status = imh_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              h_raddr    = '0;
              state_next = S_EXT_RT;
            end
          end
          default: begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_INS_CHK: begin
        if (p_rdata != '0) begin
          fin        = 1'b1;
          fin_status = imh_pkg::ST_PRESENT;
          state_next = S_IDLE;
        end else if (count >= SB'(imh_pkg::HEAP_DEPTH)) begin
          fin        = 1'b1;
          fin_status = imh_pkg::ST_FULL;
          state_next = S_IDLE;
        end else begin
          count_next = count + SB'(1);
          loc_next   = count + SB'(1);
          item_next  = '{id: in_id, cost: in_cost};
          state_next = S_UP;
        end
      end

      // Sift up: the moving item stays in registers, parents move down.
      S_UP: begin
        if (loc == SB'(1)) begin
          h_we       = 1'b1;
          p_we       = 1'b1;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          h_raddr    = AB'(parent - SB'(1));
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (item.cost < h_rdata.cost) begin
          h_wdata    = h_rdata;
          p_waddr    = h_rdata.id[PB-1:0];
          loc_next   = parent;
          state_next = S_UP;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DEC_POS: begin
        if (p_rdata == '0 || p_rdata > count) begin
          fin        = 1'b1;
          fin_status = imh_pkg::ST_ABSENT;
          state_next = S_IDLE;
        end else begin
          loc_next   = p_rdata;
          h_raddr    = AB'(p_rdata - SB'(1));
          state_next = S_DEC_CMP;
        end
      end

      S_DEC_CMP: begin
        if (in_cost < h_rdata.cost) begin
          item_next  = '{id: in_id, cost: in_cost};
          state_next = S_UP;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Extract: take the root, mark it absent, fetch the last entry.
      S_EXT_RT: begin
        res_id_next   = h_rdata.id;
        res_cost_next = h_rdata.cost;
        p_we          = 1'b1;
        p_waddr       = h_rdata.id[PB-1:0];
        p_wdata       = '0;
        count_next    = count - SB'(1);
        if (count > SB'(1)) begin
          h_raddr    = AB'(count - SB'(1));
          state_next = S_EXT_LST;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_EXT_LST: begin
        item_next  = h_rdata;
        loc_next   = SB'(1);
        state_next = S_DN;
      end

      // Sift down: the moving item stays in registers, children move up.
      S_DN: begin
        if (child > CB'(count)) begin
          h_we       = 1'b1;
          p_we       = 1'b1;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          h_raddr    = AB'(child - CB'(1));
          state_next = S_DN_L;
        end
      end

      S_DN_L: begin
        left_next    = h_rdata;
        chosen_next  = h_rdata;
        ch_slot_next = SB'(child);
        if (child < CB'(count)) begin
          h_raddr    = AB'(child);
          state_next = S_DN_R;
        end else begin
          state_next = S_DN_CMP;
        end
      end

      S_DN_R: begin
        if (left.cost > h_rdata.cost) begin
          chosen_next  = h_rdata;
          ch_slot_next = SB'(child + CB'(1));
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (item.cost > chosen.cost) begin
          h_wdata    = chosen;
          p_waddr    = chosen.id[PB-1:0];
          loc_next   = ch_slot;
          state_next = S_DN;
        end else begin
          // The subtree below is already ordered, so the item settles here.
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      count    <= count_next;
      done     <= fin;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    in_id    <= in_id_next;
    in_cost  <= in_cost_next;
    res_id   <= res_id_next;
    res_cost <= res_cost_next;
    item     <= item_next;
    left     <= left_next;
    chosen   <= chosen_next;
    loc      <= loc_next;
    ch_slot  <= ch_slot_next;
    if (fin) begin
      out_id      <= res_id_next;
      out_cost    <= res_cost_next;
      status      <= fin_status;
      entry_count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SB'(imh_pkg::HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == imh_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with entries held");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the indexed min-heap. A short directed table
// covers the empty, present, absent, tie and no-op cases. Random requests
// follow under several idle settings, then the heap is drained to empty.
// Each result is checked against a behavioral heap model or a typed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int STALL_LIMIT = 5000;

  typedef logic [1:0]                    op_t;
  typedef logic [imh_pkg::ID_BITS-1:0]   id_t;
  typedef logic [imh_pkg::COST_BITS-1:0] cost_t;
  typedef logic [imh_pkg::SLOT_BITS-1:0] count_t;

  typedef struct packed {
    id_t        id;
    cost_t      cost;
    logic [2:0] status;
    count_t     count;
  } heap_result_t;

  typedef struct {
    op_t          op;
    id_t          id;
    cost_t        cost;
    bit           typed;
    heap_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  op_t opcode = imh_pkg::OP_INSERT;
  id_t item_id = '0;
  cost_t cost = '0;
  logic busy, done;
  id_t out_id;
  cost_t out_cost;
  logic [2:0] status;
  count_t entry_count;

  // Model state of the heap.
  id_t         mdl_id [1:imh_pkg::HEAP_DEPTH];
  cost_t       mdl_cost [1:imh_pkg::HEAP_DEPTH];
  int unsigned mdl_pos [0:imh_pkg::ID_COUNT-1];
  int unsigned mdl_count;

  heap_result_t pending_results[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  always #4 clk = ~clk;

  indexed_min_heap_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .item_id(item_id), .cost(cost),
    .done(done), .out_id(out_id), .out_cost(out_cost),
    .status(status), .entry_count(entry_count)
  );

  task automatic swap_slots(input int unsigned a, input int unsigned b);
    id_t tid;
    cost_t tc;
    tid = mdl_id[a];
    tc = mdl_cost[a];
    mdl_id[a] = mdl_id[b];
    mdl_cost[a] = mdl_cost[b];
    mdl_id[b] = tid;
    mdl_cost[b] = tc;
    mdl_pos[mdl_id[a]] = a;
    mdl_pos[mdl_id[b]] = b;
  endtask

  task automatic bubble_up(input int unsigned loc);
    while (loc > 1 && mdl_cost[loc] < mdl_cost[loc / 2]) begin
      swap_slots(loc, loc / 2);
      loc = loc / 2;
    end
  endtask

  task automatic bubble_down();
    int unsigned i;
    int unsigned child;
    i = 1;
    forever begin
      child = i * 2;
      if (child > mdl_count) break;
      if (child < mdl_count && mdl_cost[child] > mdl_cost[child + 1]) child++;
      if (mdl_cost[i] > mdl_cost[child]) swap_slots(i, child);
      i = child;
    end
  endtask

  // Apply one request to the model heap and return the result it produces.
  task automatic heap_apply(input op_t op, input id_t id,
                            input cost_t c, output heap_result_t r);
    int unsigned loc;
    r.id = id;
    r.cost = '0;
    r.status = imh_pkg::ST_OK;
    case (op)
      imh_pkg::OP_INSERT: begin
        if (mdl_pos[id] != 0) r.status = imh_pkg::ST_PRESENT;
        else if (mdl_count >= imh_pkg::HEAP_DEPTH) r.status = imh_pkg::ST_FULL;
        else begin
          mdl_count++;
          mdl_id[mdl_count] = id;
          mdl_cost[mdl_count] = c;
          mdl_pos[id] = mdl_count;
          bubble_up(mdl_count);
        end
      end
      imh_pkg::OP_EXTRACT: begin
        if (mdl_count == 0) r.status = imh_pkg::ST_EMPTY;
        else begin
          r.id = mdl_id[1];
          r.cost = mdl_cost[1];
          mdl_pos[mdl_id[1]] = 0;
          if (mdl_count > 1) begin
            mdl_id[1] = mdl_id[mdl_count];
            mdl_cost[1] = mdl_cost[mdl_count];
            mdl_pos[mdl_id[1]] = 1;
          end
          mdl_count--;
          if (mdl_count > 1) bubble_down();
        end
      end
      imh_pkg::OP_LOWER: begin
        loc = mdl_pos[id];
        if (loc == 0 || loc > mdl_count) r.status = imh_pkg::ST_ABSENT;
        else if (c < mdl_cost[loc]) begin
          mdl_cost[loc] = c;
          bubble_up(loc);
        end
      end
      default: ;
    endcase
    r.count = mdl_count[imh_pkg::SLOT_BITS-1:0];
  endtask

  // Present a request and hold it until accepted; optionally idle afterwards.
  task automatic issue(input op_t op, input id_t id,
                       input cost_t c, input bit typed,
                       input heap_result_t typed_res);
    heap_result_t r;
    int gap;
    start <= 1'b1;
    opcode <= op;
    item_id <= id;
    cost <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    heap_apply(op, id, c, r);
    pending_results.push_back(typed ? typed_res : r);
    accepted++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold requests off until every outstanding result is back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic cost_t pick_cost();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom();
      2: return {$urandom_range(1) ? {imh_pkg::COST_BITS{1'b1}} :
                                     {imh_pkg::COST_BITS{1'b0}}};
      default: return $urandom_range(1000);
    endcase
  endfunction

  function automatic id_t pick_absent_id();
    id_t id;
    id = id_t'($urandom());
    while (mdl_pos[id] != 0) id = id + 1'b1;
    return id;
  endfunction

  // One random request: mostly well-formed, with some noise mixed in.
  task automatic random_request();
    int sel;
    id_t id;
    cost_t c;
    int unsigned loc;
    sel = $urandom_range(99);
    if (mdl_count > 40 && sel < 45) sel = 50;
    if (sel < 45 && mdl_count < imh_pkg::HEAP_DEPTH) begin
      issue(imh_pkg::OP_INSERT, pick_absent_id(), pick_cost(), 1'b0, '0);
    end else if (sel < 70) begin
      issue(imh_pkg::OP_EXTRACT, id_t'($urandom()), $urandom(), 1'b0, '0);
    end else if (sel < 88 && mdl_count > 0) begin
      loc = $urandom_range(mdl_count, 1);
      c = mdl_cost[loc];
      if (c != 0 && $urandom_range(3) != 0) c = $urandom_range(c - 1);
      else c = $urandom();
      issue(imh_pkg::OP_LOWER, mdl_id[loc], c, 1'b0, '0);
    end else begin
      id = id_t'($urandom());
      issue(op_t'($urandom_range(3)), id, $urandom(), 1'b0, '0);
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result id=%0d status=%0d", out_id, status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (out_id !== e.id) begin
          $error("out_id expected %0d actual %0d", e.id, out_id);
          errors++;
        end
        if (out_cost !== e.cost) begin
          $error("out_cost expected %0h actual %0h", e.cost, out_cost);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count expected %0d actual %0d", e.count, entry_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no request accepted and no result returned.
  always @(posedge clk) begin
    if (done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("indexed_min_heap_top: mismatch");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    int phase;
    int idx;

    for (idx = 0; idx < imh_pkg::ID_COUNT; idx++) mdl_pos[idx] = 0;
    mdl_count = 0;

    // Directed table; typed rows carry results readable at a glance.
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd5, 32'd77, 1'b1,
                     '{10'd5, 32'd0, imh_pkg::ST_EMPTY, 11'd0}});
    rows.push_back('{imh_pkg::OP_LOWER, 10'd7, 32'd1, 1'b1,
                     '{10'd7, 32'd0, imh_pkg::ST_ABSENT, 11'd0}});
    rows.push_back('{imh_pkg::OP_INSERT, 10'd7, 32'd100, 1'b1,
                     '{10'd7, 32'd0, imh_pkg::ST_OK, 11'd1}});
    rows.push_back('{imh_pkg::OP_INSERT, 10'd7, 32'd5, 1'b1,
                     '{10'd7, 32'd0, imh_pkg::ST_PRESENT, 11'd1}});
    rows.push_back('{imh_pkg::OP_INSERT, 10'd3, 32'hFFFF_FFFF, 1'b1,
                     '{10'd3, 32'd0, imh_pkg::ST_OK, 11'd2}});
    rows.push_back('{imh_pkg::OP_INSERT, 10'd1023, 32'd0, 1'b1,
                     '{10'd1023, 32'd0, imh_pkg::ST_OK, 11'd3}});
    rows.push_back('{imh_pkg::OP_INSERT, 10'd0, 32'd100, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_LOWER, 10'd1023, 32'd5, 1'b1,
                     '{10'd1023, 32'd0, imh_pkg::ST_OK, 11'd4}});
    rows.push_back('{imh_pkg::OP_LOWER, 10'd3, 32'd50, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_LOWER, 10'd7, 32'd100, 1'b0, '0});
    rows.push_back('{OP_NOP, 10'd9, 32'hFFFF_FFFF, 1'b1,
                     '{10'd9, 32'd0, imh_pkg::ST_OK, 11'd4}});
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd0, 32'd0, 1'b1,
                     '{10'd1023, 32'd0, imh_pkg::ST_OK, 11'd3}});
    rows.push_back('{imh_pkg::OP_INSERT, 10'd512, 32'd100, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_LOWER, 10'd1023, 32'd0, 1'b1,
                     '{10'd1023, 32'd0, imh_pkg::ST_ABSENT, 11'd4}});
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd0, 32'd0, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd0, 32'd0, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd0, 32'd0, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd0, 32'd0, 1'b0, '0});
    rows.push_back('{imh_pkg::OP_EXTRACT, 10'd1, 32'd0, 1'b1,
                     '{10'd1, 32'd0, imh_pkg::ST_EMPTY, 11'd0}});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      issue(row.op, row.id, row.cost, row.typed, row.res);
    end
    drain_results();

    // Random requests under several idle settings.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 54;
        2: idle_pct = 0;
        default: idle_pct = 9;
      endcase
      repeat (160) random_request();
      drain_results();
    end

    // Drain whatever is left, then probe the empty case once more.
    idle_pct = 9;
    while (mdl_count > 0) begin
      issue(imh_pkg::OP_EXTRACT, id_t'($urandom()), $urandom(), 1'b0, '0);
    end
    issue(imh_pkg::OP_EXTRACT, id_t'($urandom()), $urandom(), 1'b0, '0);

    drain_results();
    repeat (100) @(posedge clk);
    $display("Ran %0d requests, %0d results checked.", accepted, checked);
    $display("Covered empty, present, absent, ties, no-op and a full drain.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("indexed_min_heap_top: match");
    end else begin
      $display("indexed_min_heap_top: mismatch");
    end
    $finish;
  end

endmodule
